// File: rtl/rgb_to_display_index_dither_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the display pixel core
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_DISPLAY_INDEX_DITHER_CORE_MACROS_SVH
`define RGB_TO_DISPLAY_INDEX_DITHER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rtdd_pkg.sv
// ----------------------------------------------------------------------------
// rtdd_pkg
// Types, constants and pixel functions shared by the display pixel core.
// ----------------------------------------------------------------------------
package rtdd_pkg;

	// Sizing limits of the core.
	localparam int MAX_WIDTH = 1024;
	localparam int MAX_ZOOM  = 16;

	// Field widths.
	localparam int CH_W   = 8;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 10;
	localparam int PIX_W  = 8;
	localparam int ZOOM_W = 5;
	localparam int WIN_W  = 11;
	localparam int CC_W   = 11;
	localparam int ZCNT_W = $clog2(MAX_ZOOM + 1);

	// One past the highest column reachable by the output field.
	localparam int COL_LIM = 2 ** COL_W;

	// Largest pixel value the colour cube can produce.
	localparam int PIX_MAX = 252;

	// Queue between front and back; depth must be a power of two.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Configuration port.
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Colour cube levels per channel.
	localparam int CubeR = 6;
	localparam int CubeG = 7;
	localparam int CubeB = 6;
	localparam int CubeRStride = CubeG * CubeB;
	localparam int CubeGStride = CubeB;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_MONO   = 3'd0,
		REG_XZOOM  = 3'd1,
		REG_YZOOM  = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} reg_idx_t;

	// Configuration register set.
	typedef struct packed {
		logic              mono_mode;
		logic [ZOOM_W-1:0] x_zoom;
		logic [ZOOM_W-1:0] y_zoom;
		logic [WIN_W-1:0]  window_width;
		logic [WIN_W-1:0]  window_height;
	} cfg_t;

	// One run of output pixels, as queued from front to back.
	typedef struct packed {
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic [COL_W-1:0]  col_start;
		logic [ROW_W-1:0]  row;
		logic [ZCNT_W-1:0] count;
	} qent_t;

	// 8x8 ordered dither thresholds, indexed by column then row.
	localparam logic [7:0] THRESH [8][8] = '{
		'{8'd6,   8'd51,  8'd14,  8'd78,  8'd8,   8'd57,  8'd16,  8'd86},
		'{8'd118, 8'd22,  8'd178, 8'd34,  8'd130, 8'd25,  8'd197, 8'd37},
		'{8'd18,  8'd96,  8'd10,  8'd63,  8'd20,  8'd106, 8'd12,  8'd70},
		'{8'd219, 8'd42,  8'd145, 8'd27,  8'd243, 8'd46,  8'd160, 8'd30},
		'{8'd9,   8'd60,  8'd17,  8'd91,  8'd7,   8'd54,  8'd15,  8'd82},
		'{8'd137, 8'd26,  8'd208, 8'd40,  8'd124, 8'd23,  8'd187, 8'd36},
		'{8'd21,  8'd112, 8'd13,  8'd74,  8'd19,  8'd101, 8'd11,  8'd66},
		'{8'd254, 8'd49,  8'd169, 8'd32,  8'd230, 8'd44,  8'd152, 8'd29}
	};

	// A pixel is black when the channel sum is below three times the threshold.
	function automatic logic dither_black(input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
		input logic [2:0] col3, input logic [2:0] row3);
		logic [9:0] sum;
		logic [9:0] thr3;
		sum  = 10'(r) + 10'(g) + 10'(b);
		thr3 = 10'(THRESH[col3][row3]) * 10'd3;
		return sum < thr3;
	endfunction

	// Colour cube index plus one, 1..252.
	function automatic logic [PIX_W-1:0] cube_index(input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		logic [10:0] rs;
		logic [10:0] gs;
		logic [10:0] bs;
		logic [2:0]  rl;
		logic [2:0]  gl;
		logic [2:0]  bl;
		rs = 11'(r) * 11'(CubeR);
		gs = 11'(g) * 11'(CubeG);
		bs = 11'(b) * 11'(CubeB);
		rl = 3'(rs >> 8);
		gl = 3'(gs >> 8);
		bl = 3'(bs >> 8);
		return PIX_W'(PIX_W'(rl) * PIX_W'(CubeRStride) + PIX_W'(gl) * PIX_W'(CubeGStride)
			+ PIX_W'(bl) + PIX_W'(1));
	endfunction

endpackage

// File: rtl/rtdd_ifs.sv
// ----------------------------------------------------------------------------
// rtdd_rgb_if / rtdd_disp_if
// Valid/ready channels for RGB input items and display result items.
// ----------------------------------------------------------------------------

// RGB pixel channel.
interface rtdd_rgb_if;
	import rtdd_pkg::*;
	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;
	logic              first;
	logic [COL_W-1:0]  start_column;
	logic [ROW_W-1:0]  start_row;
	logic              single_pixel;

	modport source(output valid, red, green, blue, first, start_column, start_row,
		single_pixel, input ready);
	modport sink(input valid, red, green, blue, first, start_column, start_row,
		single_pixel, output ready);
endinterface

// Display pixel channel.
interface rtdd_disp_if;
	import rtdd_pkg::*;
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] out_column;
	logic [ROW_W-1:0] out_row;
	logic [PIX_W-1:0] pixel_value;
	logic             last;

	modport source(output valid, out_column, out_row, pixel_value, last, input ready);
	modport sink(input valid, out_column, out_row, pixel_value, last, output ready);
endinterface

// File: rtl/rtdd_regs.sv
// ----------------------------------------------------------------------------
// rtdd_regs
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module rtdd_regs
	import rtdd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign wr_en = psel && penable && pwrite && pready;
	assign idx   = paddr[4:2];
	assign cfg   = cfg_q;

	// Register writes, one register per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mono_mode     <= 1'b0;
			cfg_q.x_zoom        <= ZOOM_W'(1);
			cfg_q.y_zoom        <= ZOOM_W'(1);
			cfg_q.window_width  <= WIN_W'(512);
			cfg_q.window_height <= WIN_W'(512);
		end else if (wr_en) begin
			unique case (idx)
				REG_MONO:   cfg_q.mono_mode     <= pwdata[0];
				REG_XZOOM:  cfg_q.x_zoom        <= pwdata[ZOOM_W-1:0];
				REG_YZOOM:  cfg_q.y_zoom        <= pwdata[ZOOM_W-1:0];
				REG_WIDTH:  cfg_q.window_width  <= pwdata[WIN_W-1:0];
				REG_HEIGHT: cfg_q.window_height <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		unique case (idx)
			REG_MONO:   prdata = APB_DW'(cfg_q.mono_mode);
			REG_XZOOM:  prdata = APB_DW'(cfg_q.x_zoom);
			REG_YZOOM:  prdata = APB_DW'(cfg_q.y_zoom);
			REG_WIDTH:  prdata = APB_DW'(cfg_q.window_width);
			REG_HEIGHT: prdata = APB_DW'(cfg_q.window_height);
			default:    prdata = '0;
		endcase
	end

endmodule

// File: rtl/rtdd_front.sv
// ----------------------------------------------------------------------------
// rtdd_front
// Accepts RGB items, tracks column and row, and queues runs of output pixels.
// ----------------------------------------------------------------------------
module rtdd_front
	import rtdd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	rtdd_rgb_if.sink rgb,
	input  logic    q_full,
	output logic    q_push,
	output qent_t   q_data
);

	localparam int DW = ROW_W + 2;

	logic [CC_W-1:0]   cc_q;
	logic [ROW_W-1:0]  row_q;
	logic              rv_q;

	logic              acc;
	logic [CC_W-1:0]   cc_f;
	logic [ROW_W-1:0]  row_f;
	logic              rv_f;
	logic [DW-1:0]     diff;
	logic [WIN_W-1:0]  w_cap;
	logic [WIN_W-1:0]  lim;
	logic [ZCNT_W-1:0] zx;
	logic [ZCNT_W-1:0] zy;
	logic [CC_W:0]     col_end;
	logic [CC_W:0]     end_clip;
	logic [ZCNT_W-1:0] n_out;
	logic              wrap;

	assign rgb.ready = !q_full;
	assign acc       = rgb.valid && !q_full;

	// Apply a first pixel: load column and flipped row.
	always_comb begin
		diff = DW'(cfg.window_height) - DW'(1) - DW'(rgb.start_row);
		if (rgb.first) begin
			cc_f  = CC_W'(rgb.start_column);
			rv_f  = (WIN_W'(rgb.start_row) < cfg.window_height) && !diff[ROW_W];
			row_f = diff[ROW_W-1:0];
		end else begin
			cc_f  = cc_q;
			rv_f  = rv_q;
			row_f = row_q;
		end
	end

	// Effective limits and zoom factors.
	always_comb begin
		if (32'(cfg.window_width) > MAX_WIDTH) begin
			w_cap = WIN_W'(MAX_WIDTH);
		end else begin
			w_cap = cfg.window_width;
		end
		if (32'(w_cap) > COL_LIM) begin
			lim = WIN_W'(COL_LIM);
		end else begin
			lim = w_cap;
		end
		if (cfg.x_zoom == '0) begin
			zx = ZCNT_W'(1);
		end else if (32'(cfg.x_zoom) > MAX_ZOOM) begin
			zx = ZCNT_W'(MAX_ZOOM);
		end else begin
			zx = ZCNT_W'(cfg.x_zoom);
		end
		if (cfg.y_zoom == '0) begin
			zy = ZCNT_W'(1);
		end else if (32'(cfg.y_zoom) > MAX_ZOOM) begin
			zy = ZCNT_W'(MAX_ZOOM);
		end else begin
			zy = ZCNT_W'(cfg.y_zoom);
		end
	end

	// Run of visible copies and the wrap test after all copies.
	always_comb begin
		col_end = (CC_W+1)'(cc_f) + (CC_W+1)'(zx);
		if (col_end > (CC_W+1)'(lim)) begin
			end_clip = (CC_W+1)'(lim);
		end else begin
			end_clip = col_end;
		end
		if (end_clip > (CC_W+1)'(cc_f)) begin
			n_out = ZCNT_W'(end_clip - (CC_W+1)'(cc_f));
		end else begin
			n_out = '0;
		end
		wrap = col_end >= (CC_W+1)'(w_cap);
	end

	// Queue entry for this item.
	always_comb begin
		q_data.red       = rgb.red;
		q_data.green     = rgb.green;
		q_data.blue      = rgb.blue;
		q_data.col_start = cc_f[COL_W-1:0];
		q_data.row       = row_f;
		q_data.count     = rgb.single_pixel ? ZCNT_W'(1) : n_out;
		q_push           = acc && rv_f && (rgb.single_pixel || (n_out != '0));
	end

	// Column and row state update per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q  <= '0;
			row_q <= '0;
			rv_q  <= 1'b0;
		end else if (acc) begin
			if (!rv_f || rgb.single_pixel) begin
				cc_q  <= cc_f;
				row_q <= row_f;
				rv_q  <= rv_f;
			end else if (wrap) begin
				cc_q <= '0;
				if (row_f < ROW_W'(zy)) begin
					rv_q  <= 1'b0;
					row_q <= '0;
				end else begin
					rv_q  <= 1'b1;
					row_q <= row_f - ROW_W'(zy);
				end
			end else begin
				cc_q  <= col_end[CC_W-1:0];
				row_q <= row_f;
				rv_q  <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/rtdd_queue.sv
// ----------------------------------------------------------------------------
// rtdd_queue
// Short register queue of pixel runs between the front and the back.
// ----------------------------------------------------------------------------
module rtdd_queue
	import rtdd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	input  logic  pop,
	output qent_t head,
	output logic  full,
	output logic  empty
);

	qent_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = ent_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// File: rtl/rtdd_back.sv
// ----------------------------------------------------------------------------
// rtdd_back
// Expands queued runs into display pixels, one per cycle while disp is ready.
// ----------------------------------------------------------------------------
module rtdd_back
	import rtdd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  qent_t        head,
	input  logic         empty,
	output logic         pop,
	rtdd_disp_if.source  disp
);

	logic [ZCNT_W-1:0] idx_q;
	logic              valid_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [PIX_W-1:0]  pix_q;
	logic              last_q;

	logic              load;
	logic [COL_W-1:0]  cur_col;
	logic              is_last;
	logic [PIX_W-1:0]  pix;

	assign disp.valid       = valid_q;
	assign disp.out_column  = col_q;
	assign disp.out_row     = row_q;
	assign disp.pixel_value = pix_q;
	assign disp.last        = last_q;

	// Current copy of the head run and its pixel value.
	always_comb begin
		cur_col = head.col_start + COL_W'(idx_q);
		is_last = idx_q == (head.count - ZCNT_W'(1));
		if (cfg.mono_mode) begin
			pix = PIX_W'(dither_black(head.red, head.green, head.blue, cur_col[2:0],
				head.row[2:0]));
		end else begin
			pix = cube_index(head.red, head.green, head.blue);
		end
		load = !empty && (!valid_q || disp.ready);
		pop  = load && is_last;
	end

	// Copy counter within the head run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= idx_q + ZCNT_W'(1);
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (disp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			col_q  <= cur_col;
			row_q  <= head.row;
			pix_q  <= pix;
			last_q <= is_last;
		end
	end

endmodule

// File: rtl/rgb_to_display_index_dither_core.sv
// ----------------------------------------------------------------------------
// rgb_to_display_index_dither_core
// RGB scanline pixels to dithered mono or colour cube display pixels.
//
//   Channel   Direction  Contents
//   rgb       in         red, green, blue, first, start_column, start_row,
//                        single_pixel
//   disp      out        out_column, out_row, pixel_value, last
//   apb       in/out     five configuration registers at 4-byte strides
//
// An item is taken every cycle while the four-entry run queue has room.
// Each item yields zero to MAX_ZOOM results; the back end sends one result
// per cycle while disp is ready.
// Accepted items are registered in the run queue, then in the output register.
// Reset clears column, row and queue state and loads the register defaults.
// A stall on disp holds the output register and fills the queue before rgb.
// ----------------------------------------------------------------------------
module rgb_to_display_index_dither_core
	import rtdd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	rtdd_rgb_if.sink          rgb,
	rtdd_disp_if.source       disp
);

	cfg_t  cfg;
	logic  q_push;
	qent_t q_data;
	logic  q_pop;
	qent_t q_head;
	logic  q_full;
	logic  q_empty;

	assign pready = 1'b1;

	// Configuration registers.
	rtdd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Front: position tracking and run classification.
	rtdd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rgb    (rgb),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_data)
	);

	// Run queue.
	rtdd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Back: run expansion and pixel values.
	rtdd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (q_head),
		.empty  (q_empty),
		.pop    (q_pop),
		.disp   (disp)
	);

endmodule

// File: rtl/rtdd_checker.sv
// ----------------------------------------------------------------------------
// rtdd_checker
// Port-level assertions on the display output channel.
// ----------------------------------------------------------------------------
`include "rgb_to_display_index_dither_core_macros.svh"

module rtdd_checker
	import rtdd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             disp_valid,
	input logic             disp_ready,
	input logic [COL_W-1:0] disp_out_column,
	input logic [ROW_W-1:0] disp_out_row,
	input logic [PIX_W-1:0] disp_pixel_value,
	input logic             disp_last
);

	// A stalled result item holds its valid and payload.
	`RTDD_ASSERT_NXT(a_disp_hold, clk, arst_n, disp_valid && !disp_ready, disp_valid && $stable(disp_out_column) && $stable(disp_out_row) && $stable(disp_pixel_value) && $stable(disp_last), "display item changed while stalled")

	// Copies of one input follow in the next cycle, one column on, same row.
	`RTDD_ASSERT_NXT(a_run_step, clk, arst_n, disp_valid && disp_ready && !disp_last, disp_valid && (disp_out_column == $past(disp_out_column) + 10'd1) && $stable(disp_out_row), "replicated pixels not contiguous")

	// Pixel values stay inside the colour cube range.
	`RTDD_ASSERT_IMP(a_pix_range, clk, arst_n, disp_valid, disp_pixel_value <= PIX_W'(PIX_MAX), "pixel value out of range")

endmodule

bind rgb_to_display_index_dither_core rtdd_checker u_rtdd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.disp_valid       (disp.valid),
	.disp_ready       (disp.ready),
	.disp_out_column  (disp.out_column),
	.disp_out_row     (disp.out_row),
	.disp_pixel_value (disp.pixel_value),
	.disp_last        (disp.last)
);

// File: sim/tb_rgb_to_display_index_dither_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_display_index_dither_core
// Self-checking testbench for the RGB to display pixel core. A queue of RGB
// items feeds a clocked driver, and a clocked monitor compares every display
// pixel against a scoreboard that a local pixel predictor fills when each
// item is accepted. Register settings change between phases over APB.
// ----------------------------------------------------------------------------
module tb_rgb_to_display_index_dither_core;
	import rtdd_pkg::*;

	// One RGB input item as offered on the rgb channel.
	typedef struct packed {
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic             first;
		logic [COL_W-1:0] start_column;
		logic [ROW_W-1:0] start_row;
		logic             single_pixel;
	} rgb_item_t;

	// One display pixel as seen on the disp channel.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] value;
		logic             last;
	} disp_pix_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	rtdd_rgb_if  rgb_ch ();
	rtdd_disp_if disp_ch ();

	rgb_to_display_index_dither_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rgb     (rgb_ch),
		.disp    (disp_ch)
	);

	// Local copy of the register set.
	logic              cfg_mono;
	logic [ZOOM_W-1:0] cfg_xzoom;
	logic [ZOOM_W-1:0] cfg_yzoom;
	logic [WIN_W-1:0]  cfg_width;
	logic [WIN_W-1:0]  cfg_height;

	// Local copy of the scan position.
	logic [CC_W-1:0] col_cnt;
	logic [11:0]     row_cnt;
	logic            row_ok;

	rgb_item_t pending_items[$];
	disp_pix_t expected_pixels[$];
	rgb_item_t offered;

	int  tx_gap;
	int  rx_wait;
	bit  tx_idle_on;
	bit  rx_idle_on;
	logic long_hold_go;
	int  items_sent;
	int  live_items;
	int  pixels_checked;
	int  fail_count;
	int  settings_run;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int idle_len(input bit on);
		int p;
		if (!on) return 0;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Zoom register to repetition count.
	function automatic int zoom_of(input logic [ZOOM_W-1:0] z);
		if (z == 0) return 1;
		if (int'(z) > MAX_ZOOM) return MAX_ZOOM;
		return int'(z);
	endfunction

	// Display value of one pixel at a given column and row.
	function automatic logic [PIX_W-1:0] shade(input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g, input logic [CH_W-1:0] b, input int col, input int row);
		int sum;
		int thr;
		if (cfg_mono) begin
			sum = int'(r) + int'(g) + int'(b);
			thr = int'(THRESH[col & 7][row & 7]);
			return (sum < 3 * thr) ? 8'd1 : 8'd0;
		end
		return PIX_W'((int'(r) * 6 / 256) * 42 + (int'(g) * 7 / 256) * 6
			+ (int'(b) * 6 / 256) + 1);
	endfunction

	// Advance the scan position for one accepted item and queue its pixels.
	task automatic predict_pixels(input rgb_item_t it);
		int        fr;
		int        width;
		int        zx;
		int        zy;
		int        col;
		int        nres;
		int        i;
		disp_pix_t px;
		if (it.first) begin
			fr = int'(cfg_height) - 1 - int'(it.start_row);
			col_cnt = CC_W'(it.start_column);
			row_ok = (fr >= 0) && (fr < int'(cfg_height)) && (fr <= 1023);
			row_cnt = row_ok ? 12'(fr) : 12'd0;
		end
		if (!row_ok) return;
		live_items++;

		// A single-pixel write gives one pixel and leaves the position alone.
		if (it.single_pixel) begin
			px.col   = COL_W'(col_cnt);
			px.row   = ROW_W'(row_cnt);
			px.value = shade(it.red, it.green, it.blue, int'(col_cnt), int'(row_cnt));
			px.last  = 1'b1;
			expected_pixels.push_back(px);
			return;
		end

		// Replicate across the row, clipping at the window edge.
		width = (int'(cfg_width) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
		zx = zoom_of(cfg_xzoom);
		col = int'(col_cnt);
		nres = 0;
		for (i = 0; i < zx; i++) begin
			if (col < width && col <= 1023) begin
				px.col   = COL_W'(col);
				px.row   = ROW_W'(row_cnt);
				px.value = shade(it.red, it.green, it.blue, col, int'(row_cnt));
				px.last  = 1'b0;
				expected_pixels.push_back(px);
				nres++;
			end
			col++;
		end
		if (nres > 0) expected_pixels[expected_pixels.size() - 1].last = 1'b1;

		// Wrap to the next row up the screen, leaving the window below row 0.
		if (col >= width) begin
			zy = zoom_of(cfg_yzoom);
			col = 0;
			if (int'(row_cnt) < zy) begin
				row_ok = 1'b0;
				row_cnt = 12'd0;
			end else begin
				row_cnt = row_cnt - 12'(zy);
			end
		end
		col_cnt = CC_W'(col);
	endtask

	// RGB driver: offers pending items and predicts each one as it is taken.
	always @(posedge clk) begin : rgb_driver
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = rgb_ch.valid;
			if (rgb_ch.valid && rgb_ch.ready) begin
				predict_pixels(offered);
				items_sent++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_items.size() > 0) begin
					offered = pending_items.pop_front();
					rgb_ch.red          <= offered.red;
					rgb_ch.green        <= offered.green;
					rgb_ch.blue         <= offered.blue;
					rgb_ch.first        <= offered.first;
					rgb_ch.start_column <= offered.start_column;
					rgb_ch.start_row    <= offered.start_row;
					rgb_ch.single_pixel <= offered.single_pixel;
					nxt_valid = 1'b1;
					tx_gap = idle_len(tx_idle_on);
				end
			end
			rgb_ch.valid <= nxt_valid;
		end
	end

	// Display monitor: checks each pixel and paces the ready signal.
	always @(posedge clk) begin : disp_monitor
		disp_pix_t got;
		disp_pix_t want;
		if (arst_n) begin
			if (disp_ch.valid && disp_ch.ready) begin
				got = '{disp_ch.out_column, disp_ch.out_row, disp_ch.pixel_value, disp_ch.last};
				if (expected_pixels.size() == 0) begin
					$error("display pixel with none expected: column %0d row %0d value %0d",
						got.col, got.row, got.value);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					pixels_checked++;
					if (got.col !== want.col) begin
						$error("out_column expected %0d actual %0d", want.col, got.col);
						fail_count++;
					end
					if (got.row !== want.row) begin
						$error("out_row expected %0d actual %0d", want.row, got.row);
						fail_count++;
					end
					if (got.value !== want.value) begin
						$error("pixel_value expected %0d actual %0d", want.value, got.value);
						fail_count++;
					end
					if (got.last !== want.last) begin
						$error("last expected %0d actual %0d", want.last, got.last);
						fail_count++;
					end
				end
				rx_wait = idle_len(rx_idle_on);
			end
			if (long_hold_go) rx_wait = 300;
			disp_ch.ready <= (rx_wait == 0);
			if (rx_wait > 0) rx_wait--;
		end
	end

	// One APB register write; the local register copy follows at the access edge.
	task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_MONO:   cfg_mono   = val[0];
			REG_XZOOM:  cfg_xzoom  = val[ZOOM_W-1:0];
			REG_YZOOM:  cfg_yzoom  = val[ZOOM_W-1:0];
			REG_WIDTH:  cfg_width  = val[WIN_W-1:0];
			REG_HEIGHT: cfg_height = val[WIN_W-1:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Load a full register setting.
	task automatic load_setting(input int mono, input int xz, input int yz, input int w,
		input int h);
		apb_write(REG_MONO, APB_DW'(mono));
		apb_write(REG_XZOOM, APB_DW'(xz));
		apb_write(REG_YZOOM, APB_DW'(yz));
		apb_write(REG_WIDTH, APB_DW'(w));
		apb_write(REG_HEIGHT, APB_DW'(h));
		settings_run++;
	endtask

	// Queue one RGB item.
	task automatic add_px(input int r, input int g, input int b, input bit first,
		input int scol, input int srow, input bit single);
		rgb_item_t it;
		it.red          = CH_W'(r);
		it.green        = CH_W'(g);
		it.blue         = CH_W'(b);
		it.first        = first;
		it.start_column = COL_W'(scol);
		it.start_row    = ROW_W'(srow);
		it.single_pixel = single;
		pending_items.push_back(it);
	endtask

	// Random channel value, with the extremes weighted in.
	function automatic int rand_chan();
		int p;
		p = $urandom_range(9);
		if (p == 0) return 0;
		if (p == 1) return 255;
		return $urandom_range(255);
	endfunction

	// Queue random scanline writes: mostly well formed, some noise.
	task automatic add_scanlines(input int n_lines);
		int ln;
		int k;
		int n_px;
		int w_lim;
		int h_lim;
		int scol;
		int srow;
		w_lim = (int'(cfg_width) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
		h_lim = (int'(cfg_height) > 1024) ? 1024 : int'(cfg_height);
		for (ln = 0; ln < n_lines; ln++) begin
			if ($urandom_range(99) < 12) begin
				// Noise: every field random.
				add_px($urandom_range(255), $urandom_range(255), $urandom_range(255),
					$urandom_range(1), $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1));
			end else begin
				scol = ($urandom_range(99) < 85 && w_lim > 0) ? $urandom_range(w_lim - 1)
					: $urandom_range(1023);
				srow = ($urandom_range(99) < 90 && h_lim > 0) ? $urandom_range(h_lim - 1)
					: $urandom_range(1023);
				if ($urandom_range(99) < 10) begin
					add_px(rand_chan(), rand_chan(), rand_chan(), 1'b1, scol, srow, 1'b1);
				end else begin
					add_px(rand_chan(), rand_chan(), rand_chan(), 1'b1, scol, srow, 1'b0);
					n_px = $urandom_range(12, 1);
					for (k = 0; k < n_px; k++) begin
						add_px(rand_chan(), rand_chan(), rand_chan(), 1'b0,
							$urandom_range(1023), $urandom_range(1023),
							$urandom_range(99) < 5);
					end
				end
			end
		end
	endtask

	// Random register setting, small windows favored so that lines wrap.
	task automatic load_random_setting();
		int p;
		int xz;
		int yz;
		int w;
		int h;
		p = $urandom_range(99);
		if (p < 5) xz = ($urandom_range(1) == 0) ? 0 : $urandom_range(31, 17);
		else if (p < 55) xz = $urandom_range(3, 1);
		else if (p < 80) xz = $urandom_range(8, 4);
		else xz = $urandom_range(16, 9);
		yz = ($urandom_range(99) < 5) ? 0 : $urandom_range(16, 1);
		p = $urandom_range(99);
		if (p < 70) w = $urandom_range(48, 1);
		else if (p < 92) w = $urandom_range(1024, 49);
		else w = $urandom_range(2047, 1025);
		h = ($urandom_range(99) < 60) ? $urandom_range(40, 1) : $urandom_range(1024, 41);
		load_setting($urandom_range(1), xz, yz, w, h);
	endtask

	// Hold the sender until all pixels are back and the core has gone quiet.
	task automatic drain();
		while (pending_items.size() > 0 || rgb_ch.valid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Main stimulus sequence.
	initial begin : stimulus
		int phase;
		int item_goal;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		rgb_ch.valid        = 1'b0;
		rgb_ch.red          = '0;
		rgb_ch.green        = '0;
		rgb_ch.blue         = '0;
		rgb_ch.first        = 1'b0;
		rgb_ch.start_column = '0;
		rgb_ch.start_row    = '0;
		rgb_ch.single_pixel = 1'b0;
		disp_ch.ready       = 1'b0;
		long_hold_go = 1'b0;
		cfg_mono   = 1'b0;
		cfg_xzoom  = 5'd1;
		cfg_yzoom  = 5'd1;
		cfg_width  = 11'd512;
		cfg_height = 11'd512;
		col_cnt = '0;
		row_cnt = '0;
		row_ok  = 1'b0;
		tx_gap = 0;
		rx_wait = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		items_sent = 0;
		live_items = 0;
		pixels_checked = 0;
		fail_count = 0;
		settings_run = 1;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: colour cube extremes, single pixel, rows leaving the window.
		add_px(0, 0, 0, 1'b1, 0, 0, 1'b0);
		add_px(255, 255, 255, 1'b0, 0, 0, 1'b0);
		add_px(255, 0, 128, 1'b0, 0, 0, 1'b0);
		add_px(42, 200, 7, 1'b0, 0, 0, 1'b1);
		add_px(10, 20, 30, 1'b1, 511, 511, 1'b0);
		add_px(99, 99, 99, 1'b0, 0, 0, 1'b0);
		add_px(1, 2, 3, 1'b1, 5, 512, 1'b0);
		add_px(7, 7, 7, 1'b1, 1023, 0, 1'b0);
		add_px(128, 128, 128, 1'b0, 0, 0, 1'b0);
		drain();

		// Mono with the widest zoom: clipping at a narrow window, single pixel outside it.
		load_setting(1, 16, 3, 20, 1024);
		add_px(255, 255, 255, 1'b1, 0, 1023, 1'b0);
		add_px(0, 0, 0, 1'b0, 0, 0, 1'b0);
		add_px(100, 100, 100, 1'b1, 1000, 0, 1'b1);
		add_px(85, 85, 85, 1'b1, 8, 2, 1'b0);
		add_px(254, 255, 255, 1'b0, 0, 0, 1'b0);
		drain();

		// Out of range zoom and window values: zoom 0, zoom above the limit, wide window.
		load_setting(0, 0, 31, 2047, 2047);
		add_px(50, 60, 70, 1'b1, 1020, 0, 1'b0);
		add_px(50, 60, 70, 1'b1, 1020, 1023, 1'b0);
		add_px(200, 10, 90, 1'b0, 0, 0, 1'b0);
		add_px(30, 240, 180, 1'b0, 0, 0, 1'b0);
		add_px(120, 130, 140, 1'b0, 0, 0, 1'b0);
		add_px(5, 6, 7, 1'b0, 0, 0, 1'b0);
		drain();
		apb_write(REG_XZOOM, APB_DW'(31));
		add_px(64, 128, 192, 1'b1, 1015, 1023, 1'b0);
		drain();

		// Random phases until about 120 items have been sent in all; the first three
		// phases always run so that the long display stall is covered.
		item_goal = 120;
		phase = 0;
		while ((items_sent < item_goal || phase < 3) && phase < 60) begin
			case (phase)
				0: load_setting(0, 16, 16, 1024, 1024);
				1: load_setting(1, 1, 1, 1, 1);
				2: load_setting(1, 4, 2, 30, 64);
				default: load_random_setting();
			endcase
			tx_idle_on = (phase == 3) ? 1'b0 : ($urandom_range(3) != 0);
			rx_idle_on = (phase == 3) ? 1'b0 : ($urandom_range(3) != 0);
			add_scanlines((phase == 2) ? 8 : $urandom_range(4, 2));
			// Stall the display side for a long stretch so the core backs up.
			if (phase == 2) begin
				@(posedge clk);
				long_hold_go <= 1'b1;
				@(posedge clk);
				long_hold_go <= 1'b0;
			end
			drain();
			phase++;
		end

		$display("Sent %0d RGB items (%0d inside the window) across %0d register settings.",
			items_sent, live_items, settings_run);
		$display("Compared %0d display pixels; %0d field mismatches or stray pixels.",
			pixels_checked, fail_count);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
